/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rfmd_pkg.sv */
// ----------------------------------------------------------------------------
// rfmd_pkg
// Types, codes and the glyph table of the frequency meter display.
// ----------------------------------------------------------------------------
`default_nettype none

package rfmd_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned DWELL_W     = 8;
    localparam int unsigned SEG_W       = 7;
    localparam int unsigned SEL_W       = 2;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned DIV_CNT_W   = 5;

    // Request opcodes
    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_CLOCK_HZ = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DWELL_TICKS    = 8'd1;

    localparam logic [DATA_W-1:0]  TIMER_CLOCK_RESET = 32'd1000000;
    localparam logic [DWELL_W-1:0] DWELL_RESET       = 8'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_BCD,
        ST_DONE
    } state_t;

    // Segment patterns, bit0 = a .. bit6 = g. Six has no top bar, nine no bottom bar.
    function automatic logic [SEG_W-1:0] glyph(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7C;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h67;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/reciprocal_frequency_meter_display.sv */
// ----------------------------------------------------------------------------
// reciprocal_frequency_meter_display
// Reciprocal frequency meter with a multiplexed seven-segment display driver.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per item. s_operation = capture carries a timer
//   value; the frequency becomes timer_clock_hz / (capture - previous capture).
//   s_operation = tick advances the display multiplexer.
//   m_ channel: one result per request with the frequency, the lit digit and
//   its segment pattern, reflecting the state after that request.
//   cfg_ channel: register writes, always ready; write only while idle.
// Sequence:
//   capture: a radix-2 restoring divider (one quotient bit per cycle), then
//   the shift-add-3 decimal conversion of the saturated display value, one
//   binary bit per step (14 bits for four digits), then the result is posted.
//   tick: the result is posted directly, without division or conversion.
//   One request is in flight; s_ready is high in idle.
// Reset: aresetn (synchronous, active low) restores register defaults,
//   clears the display, the dwell counter and the previous capture.
// Stall: a finished result waits in the output register; the next request is
//   taken meanwhile and its result is held until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module reciprocal_frequency_meter_display #(
    parameter int unsigned NUM_DIGITS = 4
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_operation,
    input  wire logic [rfmd_pkg::DATA_W-1:0]         s_capture_value,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [rfmd_pkg::DATA_W-1:0]              m_frequency_hz,
    output logic [rfmd_pkg::SEL_W-1:0]               m_digit_select,
    output logic [rfmd_pkg::SEG_W-1:0]               m_segments,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rfmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rfmd_pkg::DATA_W-1:0]         cfg_data
);

    import rfmd_pkg::*;

    localparam int unsigned LIMIT  = 10 ** NUM_DIGITS - 1;
    localparam int unsigned BIN_W  = $clog2(LIMIT + 1);
    localparam int unsigned BCD_W  = 4 * NUM_DIGITS;
    localparam int unsigned BCNT_W = $clog2(BIN_W + 1);
    localparam int unsigned LIT_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    // Architectural state
    state_t                 state_reg, state_next;
    logic [DATA_W-1:0]      timer_clock_reg;
    logic [DWELL_W-1:0]     dwell_ticks_reg;
    logic [DATA_W-1:0]      prev_capture_reg;
    logic [DATA_W-1:0]      meas_freq_reg;
    logic [3:0]             digit_buffer_reg [NUM_DIGITS];
    logic [DWELL_W-1:0]     dwell_cnt_reg;
    logic [LIT_W-1:0]       lit_digit_reg;

    // Divider and decimal conversion
    logic [DATA_W-1:0]      rem_reg, rem_next;
    logic [DATA_W-1:0]      quo_reg, quo_next;
    logic [DATA_W-1:0]      dvsr_reg;
    logic                   zero_div_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [BIN_W-1:0]       bin_reg;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BCNT_W-1:0]      bcd_cnt_reg;
    logic [DATA_W+1:0]      trial;
    logic                   trial_ge;
    logic [DATA_W-1:0]      freq_final;
    logic [BCD_W-1:0]       bcd_adj;

    // Output register
    logic                   m_valid_reg;
    logic [DATA_W-1:0]      m_freq_reg;
    logic [SEL_W-1:0]       m_sel_reg;
    logic [SEG_W-1:0]       m_seg_reg;

    logic                   in_fire;
    logic                   out_free;
    logic                   div_last;
    logic                   bcd_last;
    logic [DATA_W-1:0]      lit_ext;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign div_last  = (div_cnt_reg == DIV_CNT_W'(DATA_W - 1));
    assign bcd_last  = (bcd_cnt_reg == BCNT_W'(BIN_W - 1));
    assign lit_ext   = DATA_W'(lit_digit_reg);

    assign m_valid        = m_valid_reg;
    assign m_frequency_hz = m_freq_reg;
    assign m_digit_select = m_sel_reg;
    assign m_segments     = m_seg_reg;

    // One restoring division step: shift in the next dividend bit, try subtract
    always_comb begin
        trial    = {1'b0, rem_reg, quo_reg[DATA_W-1]} - {2'b00, dvsr_reg};
        trial_ge = !trial[DATA_W+1];
        rem_next = trial_ge ? trial[DATA_W-1:0] : {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
        quo_next = {quo_reg[DATA_W-2:0], trial_ge};
        freq_final = zero_div_reg ? '0 : quo_next;
    end

    // Shift-add-3 step: correct each digit, then shift in one binary bit
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ? bcd_reg[4*d +: 4] + 4'd3
                                                           : bcd_reg[4*d +: 4];
        end
        bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (s_operation == OP_CAPTURE) ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    state_next = ST_BCD;
                end
            end
            ST_BCD: begin
                if (bcd_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_clock_reg <= TIMER_CLOCK_RESET;
            dwell_ticks_reg <= DWELL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_TIMER_CLOCK_HZ) begin
                timer_clock_reg <= cfg_data;
            end else if (cfg_index == CFG_DWELL_TICKS) begin
                dwell_ticks_reg <= cfg_data[DWELL_W-1:0];
            end
        end
    end

    // Measurement and display state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_capture_reg <= '0;
            meas_freq_reg    <= '0;
            dwell_cnt_reg    <= '0;
            lit_digit_reg    <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                digit_buffer_reg[i] <= '0;
            end
        end else begin
            if (in_fire && s_operation == OP_CAPTURE) begin
                prev_capture_reg <= s_capture_value;
            end
            if (in_fire && s_operation == OP_TICK) begin
                if (dwell_cnt_reg < dwell_ticks_reg) begin
                    dwell_cnt_reg <= dwell_cnt_reg + DWELL_W'(1);
                end else begin
                    dwell_cnt_reg <= '0;
                    if (lit_ext == DATA_W'(NUM_DIGITS - 1)) begin
                        lit_digit_reg <= '0;
                    end else begin
                        lit_digit_reg <= lit_digit_reg + LIT_W'(1);
                    end
                end
            end
            if (state_reg == ST_DIV && div_last) begin
                meas_freq_reg <= freq_final;
            end
            if (state_reg == ST_BCD && bcd_last) begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    digit_buffer_reg[i] <= bcd_next[4*i +: 4];
                end
            end
        end
    end

    // Divider and decimal conversion datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
            bcd_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    div_cnt_reg <= '0;
                    bcd_cnt_reg <= '0;
                end
                ST_DIV: begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                end
                ST_BCD: begin
                    bcd_cnt_reg <= bcd_cnt_reg + BCNT_W'(1);
                end
                ST_DONE: begin
                    div_cnt_reg <= '0;
                    bcd_cnt_reg <= '0;
                end
                default: begin
                    div_cnt_reg <= '0;
                    bcd_cnt_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && s_operation == OP_CAPTURE) begin
            dvsr_reg     <= s_capture_value - prev_capture_reg;
            zero_div_reg <= (s_capture_value == prev_capture_reg);
            quo_reg      <= timer_clock_reg;
            rem_reg      <= '0;
        end else if (state_reg == ST_DIV) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (state_reg == ST_DIV && div_last) begin
            // display saturates at all nines
            bin_reg <= (freq_final > DATA_W'(LIMIT)) ? BIN_W'(LIMIT) : freq_final[BIN_W-1:0];
            bcd_reg <= '0;
        end else if (state_reg == ST_BCD) begin
            bin_reg <= {bin_reg[BIN_W-2:0], 1'b0};
            bcd_reg <= bcd_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_freq_reg <= meas_freq_reg;
            m_sel_reg  <= lit_ext[SEL_W-1:0];
            m_seg_reg  <= glyph(digit_buffer_reg[lit_digit_reg]);
        end
    end

    // Assertions
    `ASSERT_IMPL(a_lit_in_range, aclk, aresetn, 1'b1, lit_ext < DATA_W'(NUM_DIGITS), "lit digit out of range")
    `ASSERT_IMPL(a_digit_decimal, aclk, aresetn, 1'b1, digit_buffer_reg[lit_digit_reg] < 4'd10, "digit buffer holds non-decimal")
    `ASSERT_NEXT(a_capture_divides, aclk, aresetn, in_fire && s_operation == OP_CAPTURE, state_reg == ST_DIV, "capture did not start divide")
    `ASSERT_NEXT(a_done_posts, aclk, aresetn, state_reg == ST_DONE && out_free, m_valid_reg && state_reg == ST_IDLE, "result not posted")

endmodule

`default_nettype wire

/* dv/rfmd_checker.sv */
// ----------------------------------------------------------------------------
// rfmd_checker
// Watches the request, result and register channels of the frequency meter,
// keeps a cycle-free model of its state and compares every result, field by
// field, with the reading that the model expects for the oldest open request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfmd_checker #(
    parameter int unsigned NUM_DIGITS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_operation,
    input  logic [rfmd_pkg::DATA_W-1:0]         s_capture_value,

    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [rfmd_pkg::DATA_W-1:0]         m_frequency_hz,
    input  logic [rfmd_pkg::SEL_W-1:0]          m_digit_select,
    input  logic [rfmd_pkg::SEG_W-1:0]          m_segments,

    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [rfmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rfmd_pkg::DATA_W-1:0]         cfg_data,

    output int unsigned                         fail_count,
    output int unsigned                         pending_results,
    output int unsigned                         results_checked
);
    import rfmd_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] freq;
        logic [SEL_W-1:0]  sel;
        logic [SEG_W-1:0]  seg;
    } reading_t;

    localparam logic [SEG_W-1:0] SEG_FONT [0:9] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7C, 7'h07, 7'h7F, 7'h67
    };
    localparam logic [DATA_W-1:0] DISPLAY_MAX = DATA_W'(10 ** NUM_DIGITS - 1);

    // model state
    logic [DATA_W-1:0]  timer_hz;
    logic [DWELL_W-1:0] dwell_limit;
    logic [DATA_W-1:0]  last_capture;
    logic [DATA_W-1:0]  freq_now;
    logic [3:0]         digit_buf [NUM_DIGITS];
    logic [DWELL_W-1:0] dwell_cnt;
    int unsigned        lit;

    reading_t    expected_readings [$];
    int unsigned errors = 0;
    int unsigned checked = 0;
    int unsigned open_cnt = 0;

    assign fail_count      = errors;
    assign pending_results = open_cnt;
    assign results_checked = checked;

    function automatic void reset_meter();
        timer_hz     = TIMER_CLOCK_RESET;
        dwell_limit  = DWELL_RESET;
        last_capture = '0;
        freq_now     = '0;
        dwell_cnt    = '0;
        lit          = 0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_buf[i] = '0;
        end
    endfunction

    function automatic reading_t meter_update(logic op, logic [DATA_W-1:0] cap);
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] shown;
        reading_t          r;
        if (op == OP_CAPTURE) begin
            span = cap - last_capture;   // wraps modulo 2^32
            if (span == '0 || timer_hz == '0) begin
                freq_now = '0;
            end else begin
                freq_now = timer_hz / span;
            end
            last_capture = cap;
            shown = (freq_now > DISPLAY_MAX) ? DISPLAY_MAX : freq_now;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                digit_buf[i] = 4'(shown % 10);
                shown        = shown / 10;
            end
        end else begin
            // a counter left above a lowered dwell also advances here
            if (dwell_cnt < dwell_limit) begin
                dwell_cnt = dwell_cnt + 1'b1;
            end else begin
                dwell_cnt = '0;
                lit       = (lit + 1 >= NUM_DIGITS) ? 0 : lit + 1;
            end
        end
        r.freq = freq_now;
        r.sel  = SEL_W'(lit);
        r.seg  = SEG_FONT[digit_buf[lit]];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            reset_meter();
            expected_readings.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_TIMER_CLOCK_HZ) begin
                    timer_hz = cfg_data;
                end else if (cfg_index == CFG_DWELL_TICKS) begin
                    dwell_limit = cfg_data[DWELL_W-1:0];
                end
            end
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch($sformatf("result with no open request, freq %0d",
                                              m_frequency_hz));
                end else begin
                    want = expected_readings.pop_front();
                    checked++;
                    if (m_frequency_hz !== want.freq) begin
                        report_mismatch($sformatf("frequency_hz got %0d expected %0d",
                                                  m_frequency_hz, want.freq));
                    end
                    if (m_digit_select !== want.sel) begin
                        report_mismatch($sformatf("digit_select got %0d expected %0d",
                                                  m_digit_select, want.sel));
                    end
                    if (m_segments !== want.seg) begin
                        report_mismatch($sformatf("segments got %h expected %h",
                                                  m_segments, want.seg));
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_readings.push_back(meter_update(s_operation, s_capture_value));
            end
        end
        open_cnt <= expected_readings.size();
    end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the reciprocal frequency meter display: directed
// corner cases, then random captures and ticks over several register
// settings with bursty requests and a stalling result consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import rfmd_pkg::*;

    localparam int unsigned PHASES        = 6;
    localparam int unsigned PHASE_ITEMS   = 70;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned TAIL_CYCLES   = 60;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 8'hFF;
    localparam logic [DATA_W-1:0]      FULL_SCALE   = '1;

    logic                   aclk            = 1'b0;
    logic                   aresetn         = 1'b0;
    logic                   s_valid         = 1'b0;
    logic                   s_ready;
    logic                   s_operation     = OP_CAPTURE;
    logic [DATA_W-1:0]      s_capture_value = '0;
    logic                   m_valid;
    logic                   m_ready         = 1'b0;
    logic [DATA_W-1:0]      m_frequency_hz;
    logic [SEL_W-1:0]       m_digit_select;
    logic [SEG_W-1:0]       m_segments;
    logic                   cfg_valid       = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index       = '0;
    logic [DATA_W-1:0]      cfg_data        = '0;

    int unsigned fail_count;
    int unsigned pending_results;
    int unsigned results_checked;

    bit                hold_req      = 1'b0;
    int unsigned       captures_sent = 0;
    int unsigned       ticks_sent    = 0;
    int unsigned       reg_writes    = 0;
    logic [DATA_W-1:0] last_cap      = '0;
    logic [DATA_W-1:0] clk_setting   = TIMER_CLOCK_RESET;

    always #4 aclk = ~aclk;

    reciprocal_frequency_meter_display dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_capture_value (s_capture_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frequency_hz  (m_frequency_hz),
        .m_digit_select  (m_digit_select),
        .m_segments      (m_segments),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    rfmd_checker meter_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_capture_value (s_capture_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frequency_hz  (m_frequency_hz),
        .m_digit_select  (m_digit_select),
        .m_segments      (m_segments),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    // Present one request and hold it until the block takes it.
    task automatic drive_item(input logic op, input logic [DATA_W-1:0] cap);
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_capture_value <= cap;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_CAPTURE) begin
            last_cap = cap;
            captures_sent++;
        end else begin
            ticks_sent++;
        end
    endtask

    task automatic sender_gap(input int unsigned n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Stop sending and wait for every open request to come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_TIMER_CLOCK_HZ) begin
            clk_setting = val;
        end
        reg_writes++;
    endtask

    // Result consumer: switches between free flow, coin-flip and heavy stalls,
    // and on request holds off completely for a long stretch.
    initial begin
        int unsigned mode;
        int unsigned mode_left;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        #3_000_000;
        $display("Timeout: results still open %0d", pending_results);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int unsigned       burst_left;
        logic [DATA_W-1:0] span;
        burst_left = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings
        drive_item(OP_CAPTURE, '0);            // first capture, zero interval
        drive_item(OP_CAPTURE, 32'd1000);      // 1000 Hz
        drive_item(OP_CAPTURE, 32'd1000);      // repeated capture
        drive_item(OP_CAPTURE, 32'd1001);      // 1 MHz, display saturates
        drive_item(OP_CAPTURE, FULL_SCALE);
        drive_item(OP_CAPTURE, 32'h0000_0FFF); // wraps through zero
        repeat (7) drive_item(OP_TICK, $urandom);

        drain();
        write_reg(CFG_TIMER_CLOCK_HZ, FULL_SCALE);
        write_reg(CFG_DWELL_TICKS, '0);
        write_reg(CFG_UNMAPPED, $urandom);     // must be dropped
        drive_item(OP_CAPTURE, last_cap + 1);
        drive_item(OP_CAPTURE, last_cap + 32'h0001_0000);
        drive_item(OP_CAPTURE, last_cap + 32'd429497);   // exactly 9999
        repeat (4) drive_item(OP_TICK, $urandom);

        drain();
        write_reg(CFG_TIMER_CLOCK_HZ, '0);
        drive_item(OP_CAPTURE, last_cap + 32'd12345);

        // leave the dwell counter above a lowered dwell
        drain();
        write_reg(CFG_TIMER_CLOCK_HZ, TIMER_CLOCK_RESET);
        write_reg(CFG_DWELL_TICKS, 32'd255);
        repeat (4) drive_item(OP_TICK, $urandom);
        drain();
        write_reg(CFG_DWELL_TICKS, 32'd2);
        drive_item(OP_TICK, $urandom);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin
                    write_reg(CFG_TIMER_CLOCK_HZ, TIMER_CLOCK_RESET);
                    write_reg(CFG_DWELL_TICKS, '0);
                end
                1: begin
                    write_reg(CFG_TIMER_CLOCK_HZ, FULL_SCALE);
                    write_reg(CFG_DWELL_TICKS, 32'd255);
                end
                2: begin
                    write_reg(CFG_TIMER_CLOCK_HZ, 32'd1);
                    write_reg(CFG_DWELL_TICKS, 32'd1);
                end
                3: begin
                    write_reg(CFG_TIMER_CLOCK_HZ, $urandom);
                    write_reg(CFG_DWELL_TICKS, $urandom_range(0, 3));
                end
                4: begin
                    write_reg(CFG_TIMER_CLOCK_HZ, $urandom_range(1000, 50_000_000));
                    write_reg(CFG_DWELL_TICKS, $urandom_range(0, 255));
                end
                default: begin
                    write_reg(CFG_TIMER_CLOCK_HZ, $urandom_range(0, 1) ? '0 : $urandom);
                    write_reg(CFG_DWELL_TICKS, $urandom_range(0, 2));
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == 20) begin
                    // consumer blocks while requests keep coming: input must stall
                    hold_req = 1'b1;
                    repeat (10) drive_item(OP_TICK, $urandom);
                end
                if (p == 4 && n == 30) begin
                    drain();
                end
                if (burst_left == 0) begin
                    sender_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;

                if ($urandom_range(0, 1)) begin
                    drive_item(OP_TICK, $urandom);
                end else begin
                    case ($urandom_range(0, 9))
                        0:       span = '0;
                        1:       span = $urandom_range(1, 16);
                        2, 3:    span = $urandom - last_cap;   // fully random capture
                        default: span = (clk_setting == '0) ? $urandom
                                        : clk_setting / $urandom_range(1, 12000);
                    endcase
                    drive_item(OP_CAPTURE, last_cap + span);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d captures and %0d ticks across %0d register writes;",
                 captures_sent, ticks_sent, reg_writes);
        $display("%0d results compared, %0d mismatches.", results_checked, fail_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
